### rtl/sle_pkg.sv
// Shared types and constants for the serial line editor with echo queue.
package sle_pkg;

   localparam logic [1:0] KIND_RX       = 2'd0;
   localparam logic [1:0] KIND_TX_READY = 2'd1;
   localparam logic [1:0] KIND_HOST     = 2'd2;
   localparam logic [1:0] KIND_READ     = 2'd3;

   localparam logic [7:0] CH_LOWER = 8'h20;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_NUL   = 8'h00;

   localparam int REQ_DATA_W = 16;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_USER_W = 2;

   // up to three bytes queued by one request
   typedef struct packed {
      logic [1:0] count;
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
   } enq_type;

   typedef struct packed {
      logic       line_done;
      logic [4:0] line_length;
      logic [7:0] read_char;
   } line_res_type;

   typedef struct packed {
      logic       send_valid;
      logic [7:0] send_byte;
      logic       queue_full;
      logic       sender_busy;
   } queue_res_type;

endpackage

### rtl/sle_line.sv
// Line editor: line store memory, line position and echo byte selection.
module sle_line import sle_pkg::*; #(
   parameter int LINE_DEPTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         take,
   input  logic [1:0]   kind,
   input  logic [7:0]   data,
   input  logic [4:0]   read_index,
   output enq_type      echo,
   output line_res_type res
);

   localparam int LW = $clog2(LINE_DEPTH);
   localparam logic [LW-1:0] LAST_POS = LW'(LINE_DEPTH - 1);
   localparam logic [LW+4:0] DEPTH_X  = (LW+5)'(LINE_DEPTH);

   logic [7:0]    line_mem [LINE_DEPTH];
   logic [7:0]    mem_q_ff;
   logic [LW-1:0] pos_ff, pos_in;
   logic          done_ff;
   logic [4:0]    length_ff;
   logic          rd_zero_ff;

   logic [7:0]    ch, low;
   logic          is_cr, is_bs, is_pr, room;
   logic          mem_we;
   logic [7:0]    mem_wdata;
   logic [LW+4:0] ridx_x, pos_x;
   logic          in_range;

   assign ch       = {1'b0, data[6:0]};
   assign low      = ch | CH_LOWER;
   assign is_cr    = (kind == KIND_RX) && (ch == CH_CR);
   assign is_bs    = (kind == KIND_RX) && (ch == CH_BS) && (pos_ff != '0);
   assign is_pr    = (kind == KIND_RX) && (ch >= CH_SPACE);
   assign room     = pos_ff < LAST_POS;
   assign ridx_x   = (LW+5)'(read_index);
   assign pos_x    = (LW+5)'(pos_ff);
   assign in_range = ridx_x < DEPTH_X;

   always_comb begin
      pos_in    = pos_ff;
      mem_we    = 1'b0;
      mem_wdata = CH_NUL;
      echo      = '{count: 2'd0, b0: CH_CR, b1: CH_LF, b2: CH_BS};
      if (is_cr) begin
         pos_in     = '0;
         mem_we     = take;
         echo.count = 2'd2;
      end else if (is_bs) begin
         pos_in = pos_ff - 1'b1;
         echo   = '{count: 2'd3, b0: CH_BS, b1: CH_SPACE, b2: CH_BS};
      end else if (is_pr && room) begin
         pos_in     = pos_ff + 1'b1;
         mem_we     = take;
         mem_wdata  = low;
         echo.count = 2'd1;
         echo.b0    = low;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[pos_ff] <= mem_wdata;
      end
      if (take && kind == KIND_READ) begin
         mem_q_ff <= line_mem[ridx_x[LW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (take) begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         done_ff    <= is_cr;
         length_ff  <= is_cr ? pos_x[4:0] : 5'd0;
         rd_zero_ff <= (kind != KIND_READ) || !in_range;
      end
   end

   assign res.line_done   = done_ff;
   assign res.line_length = length_ff;
   assign res.read_char   = rd_zero_ff ? CH_NUL : mem_q_ff;

endmodule

### rtl/sle_queue.sv
// Send ring queue: queue memory, pointers, sender flag and write drain buffer.
module sle_queue import sle_pkg::*; #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          take,
   input  logic [1:0]    kind,
   input  logic [7:0]    data,
   input  enq_type       echo,
   output logic          wr_pending,
   output queue_res_type res
);

   localparam int QW = $clog2(QUEUE_DEPTH);
   localparam logic [QW-1:0] LAST    = QW'(QUEUE_DEPTH - 1);
   localparam logic [QW:0]   DEPTH_X = (QW+1)'(QUEUE_DEPTH);

   logic [7:0]    queue_mem [QUEUE_DEPTH];
   logic [7:0]    mem_q_ff;
   logic [QW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic          full_ff, full_in, sending_ff, sending_in;
   logic [1:0]    pend_cnt_ff, pend_cnt_in;
   logic [7:0]    pend_b0_ff, pend_b1_ff;
   logic [QW-1:0] pend_addr_ff, pend_addr_in;
   logic          send_ff, from_mem_ff;
   logic [7:0]    fwd_ff;
   logic          full_out_ff, busy_out_ff;

   enq_type       enq;
   logic [QW:0]   rd_x, wr_x, space, n_x, wr_sum;
   logic [1:0]    k;
   logic [QW-1:0] wr_new, rd_inc, wr_inc, pend_inc;
   logic          full_enq, busy_enq, kick, step, nonempty, send;
   logic          mem_we;
   logic [QW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;

   always_comb begin
      enq = echo;
      if (kind == KIND_HOST) begin
         enq.count = 2'd1;
         enq.b0    = data;
      end else if (kind != KIND_RX) begin
         enq.count = 2'd0;
      end
   end

   assign rd_x = (QW+1)'(rd_ff);
   assign wr_x = (QW+1)'(wr_ff);
   assign n_x  = (QW+1)'(enq.count);

   always_comb begin
      if (full_ff) begin
         space = '0;
      end else if (rd_ff == wr_ff) begin
         space = DEPTH_X;
      end else if (rd_ff > wr_ff) begin
         space = rd_x - wr_x;
      end else begin
         space = rd_x + DEPTH_X - wr_x;
      end
   end

   assign k        = (space < n_x) ? space[1:0] : enq.count;
   assign wr_sum   = wr_x + (QW+1)'(k);
   assign wr_new   = (wr_sum >= DEPTH_X) ? QW'(wr_sum - DEPTH_X) : wr_sum[QW-1:0];
   assign rd_inc   = (rd_ff == LAST) ? '0 : rd_ff + 1'b1;
   assign wr_inc   = (wr_ff == LAST) ? '0 : wr_ff + 1'b1;
   assign pend_inc = (pend_addr_ff == LAST) ? '0 : pend_addr_ff + 1'b1;

   assign full_enq = full_ff || ((k != 2'd0) && (wr_new == rd_ff));
   assign busy_enq = sending_ff || (k != 2'd0);
   assign kick     = !sending_ff && (k != 2'd0);
   assign step     = (kind == KIND_TX_READY) || kick;
   assign nonempty = (rd_ff != wr_new) || full_enq;
   assign send     = step && nonempty;

   always_comb begin
      wr_in        = wr_ff;
      rd_in        = rd_ff;
      full_in      = full_ff;
      sending_in   = sending_ff;
      pend_cnt_in  = pend_cnt_ff;
      pend_addr_in = pend_addr_ff;
      mem_we       = 1'b0;
      mem_waddr    = pend_addr_ff;
      mem_wdata    = pend_b0_ff;
      if (take) begin
         wr_in        = wr_new;
         rd_in        = send ? rd_inc : rd_ff;
         full_in      = send ? 1'b0 : full_enq;
         sending_in   = (step && !nonempty) ? 1'b0 : busy_enq;
         pend_cnt_in  = (k == 2'd0) ? 2'd0 : k - 1'b1;
         pend_addr_in = wr_inc;
         mem_we       = k != 2'd0;
         mem_waddr    = wr_ff;
         mem_wdata    = enq.b0;
      end else if (pend_cnt_ff != 2'd0) begin
         pend_cnt_in  = pend_cnt_ff - 1'b1;
         pend_addr_in = pend_inc;
         mem_we       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         queue_mem[mem_waddr] <= mem_wdata;
      end
      if (take && kind == KIND_TX_READY) begin
         mem_q_ff <= queue_mem[rd_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff       <= '0;
         rd_ff       <= '0;
         full_ff     <= 1'b0;
         sending_ff  <= 1'b0;
         pend_cnt_ff <= 2'd0;
      end else begin
         wr_ff       <= wr_in;
         rd_ff       <= rd_in;
         full_ff     <= full_in;
         sending_ff  <= sending_in;
         pend_cnt_ff <= pend_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      if (take) begin
         pend_b0_ff  <= enq.b1;
         pend_b1_ff  <= enq.b2;
         send_ff     <= send;
         from_mem_ff <= kind == KIND_TX_READY;
         fwd_ff      <= enq.b0;
         full_out_ff <= full_in;
         busy_out_ff <= sending_in;
      end else if (pend_cnt_ff != 2'd0) begin
         pend_b0_ff <= pend_b1_ff;
      end
   end

   assign wr_pending      = pend_cnt_ff != 2'd0;
   assign res.send_valid  = send_ff;
   assign res.send_byte   = !send_ff ? CH_NUL : (from_mem_ff ? mem_q_ff : fwd_ff);
   assign res.queue_full  = full_out_ff;
   assign res.sender_busy = busy_out_ff;

endmodule

### rtl/serial_line_editor_with_echo_queue.sv
// Top level: request intake, line editor, send queue and response register.
// Results are registered in the line editor and queue, then in the response register.
// Throughput: 1 request per cycle while the response path moves; a request queuing more
// than one byte closes the intake until its later bytes pass the single queue write port.
// Reset: synchronous, clears line position, queue pointers, flags and valids;
// memories keep their contents and need no clearing.
module serial_line_editor_with_echo_queue import sle_pkg::*; #(
   parameter int LINE_DEPTH  = 32,
   parameter int QUEUE_DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // data[7:0], read_index[12:8]
   input  logic [REQ_USER_W-1:0] req_tuser,  // kind[1:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // send_byte[7:0], line_length[12:8], read_char[20:13], queue_full[21],
   // sender_busy[22]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [RSP_USER_W-1:0] rsp_tuser   // send_valid[0], line_done[1]
);

   logic                  take;
   logic                  s1_valid_ff, out_valid_ff;
   logic                  s1_move;
   logic                  wr_pending;
   enq_type               echo;
   line_res_type          line_res;
   queue_res_type         queue_res;
   logic [RSP_DATA_W-1:0] out_data_ff;
   logic [RSP_USER_W-1:0] out_user_ff;

   assign s1_move    = !out_valid_ff || rsp_tready;
   assign req_tready = !reset && !wr_pending && (!s1_valid_ff || s1_move);
   assign take       = req_tvalid && req_tready;

   sle_line #(.LINE_DEPTH(LINE_DEPTH)) u_line (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .kind       (req_tuser),
      .data       (req_tdata[7:0]),
      .read_index (req_tdata[12:8]),
      .echo       (echo),
      .res        (line_res)
   );

   sle_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .kind       (req_tuser),
      .data       (req_tdata[7:0]),
      .echo       (echo),
      .wr_pending (wr_pending),
      .res        (queue_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move && s1_valid_ff) begin
         out_data_ff <= {1'b0, queue_res.sender_busy, queue_res.queue_full,
                         line_res.read_char, line_res.line_length,
                         queue_res.send_byte};
         out_user_ff <= {line_res.line_done, queue_res.send_valid};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

endmodule

### rtl/sle_checker.sv
// Port-level checks for the serial line editor, bound to the top level.
module sle_checker import sle_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[0] || rsp_tdata[7:0] == 8'd0)
                     && (rsp_tuser[1] || rsp_tdata[12:8] == 5'd0))
      else $error("unflagged field not zero");

   a_cr_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata[22])
      else $error("sender idle after line end echo");

   a_full_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[21] |-> rsp_tdata[22])
      else $error("queue full while sender idle");

endmodule

bind serial_line_editor_with_echo_queue sle_checker u_sle_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

### test/serial_line_editor_with_echo_queue_tb.sv
// Self-checking testbench for the serial line editor with echo queue.
module serial_line_editor_with_echo_queue_tb;
   import sle_pkg::*;

   localparam int LINE_DEPTH      = 32;
   localparam int QUEUE_DEPTH     = 64;
   localparam int LW              = $clog2(LINE_DEPTH);
   localparam int QW              = $clog2(QUEUE_DEPTH);
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int STALL_LIMIT     = 4000;
   localparam logic [7:0] CH_MASK = 8'h7F;
   localparam logic [7:0] BIT7    = 8'h80;

   typedef struct packed {
      logic       send_valid;
      logic [7:0] send_byte;
      logic       line_done;
      logic [4:0] line_length;
      logic [7:0] read_char;
      logic       queue_full;
      logic       sender_busy;
   } console_out_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // data[7:0], read_index[12:8]
   logic [REQ_USER_W-1:0] req_tuser = '0;  // kind[1:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // send_byte[7:0], line_length[12:8], read_char[20:13], queue_full[21],
   // sender_busy[22]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;  // send_valid[0], line_done[1]

   // predicted block state
   logic [7:0]    line_mem [LINE_DEPTH];
   bit            line_mem_set [LINE_DEPTH];
   logic [LW-1:0] line_pos = '0;
   logic [7:0]    echo_mem [QUEUE_DEPTH];
   logic [QW-1:0] echo_wr = '0;
   logic [QW-1:0] echo_rd = '0;
   bit            echo_full = 1'b0;
   bit            tx_busy = 1'b0;
   bit            tx_kick = 1'b0;

   console_out_type console_out_q[$];
   int mismatch_count = 0;
   int sent_total = 0;
   int quiet_cycles = 0;
   bit sender_idle_en = 1'b1;
   bit sink_idle_en = 1'b1;
   bit hold_off_req = 1'b0;

   serial_line_editor_with_echo_queue #(
      .LINE_DEPTH (LINE_DEPTH),
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always #6 clock = ~clock;

   function automatic void push_echo(logic [7:0] b);
      if (echo_full) return;
      echo_mem[echo_wr] = b;
      echo_wr = QW'((echo_wr + 1) % QUEUE_DEPTH);
      if (echo_wr == echo_rd) echo_full = 1'b1;
      if (!tx_busy) begin
         tx_busy = 1'b1;
         tx_kick = 1'b1;
      end
   endfunction

   function automatic console_out_type console_event(logic [1:0] kind, logic [7:0] data,
                                                     logic [4:0] idx);
      console_out_type r;
      logic [7:0] ch;
      r = '0;
      tx_kick = 1'b0;
      ch = data & CH_MASK;
      case (kind)
         KIND_RX: begin
            if (ch == CH_CR) begin
               line_mem[line_pos] = CH_NUL;
               line_mem_set[line_pos] = 1'b1;
               r.line_done = 1'b1;
               r.line_length = line_pos[4:0];
               line_pos = '0;
               push_echo(CH_CR);
               push_echo(CH_LF);
            end else if (ch == CH_BS && line_pos > 0) begin
               line_pos--;
               push_echo(CH_BS);
               push_echo(CH_SPACE);
               push_echo(CH_BS);
            end else if (ch >= CH_SPACE) begin
               ch = ch | CH_LOWER;
               if (line_pos < LINE_DEPTH - 1) begin
                  line_mem[line_pos] = ch;
                  line_mem_set[line_pos] = 1'b1;
                  line_pos++;
                  push_echo(ch);
               end
            end
         end
         KIND_HOST: push_echo(data);
         KIND_READ: r.read_char = line_mem[idx];
         default: ;
      endcase
      if (kind == KIND_TX_READY || tx_kick) begin
         if (echo_rd != echo_wr || echo_full) begin
            r.send_valid = 1'b1;
            r.send_byte = echo_mem[echo_rd];
            echo_rd = QW'((echo_rd + 1) % QUEUE_DEPTH);
            echo_full = 1'b0;
         end else begin
            tx_busy = 1'b0;
         end
      end
      tx_kick = 1'b0;
      r.queue_full = echo_full;
      r.sender_busy = tx_busy;
      return r;
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] typed_char();
      int r;
      logic [7:0] hi;
      r = $urandom_range(0, 99);
      hi = $urandom_range(0, 1) ? BIT7 : 8'h00;
      if (r < 80) return 8'($urandom_range(8'h20, 8'h7E)) | hi;
      if (r < 92) return CH_BS | hi;
      return 8'($urandom_range(0, 255));
   endfunction

   // only entries written since reset may be read back
   function automatic int pick_stored_index();
      int idx_list[$];
      for (int i = 0; i < LINE_DEPTH; i++)
         if (line_mem_set[LW'(i)]) idx_list.push_back(i);
      if (idx_list.size() == 0) return -1;
      if (line_mem_set[LINE_DEPTH-1] && $urandom_range(0, 3) == 0) return LINE_DEPTH - 1;
      return idx_list[$urandom_range(0, idx_list.size() - 1)];
   endfunction

   function automatic void flag_field(string field, logic [7:0] want, logic [7:0] got);
      if (got === want) return;
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch on %s: expected %h, got %h", field, want, got);
   endfunction

   task automatic send_request(logic [1:0] kind, logic [7:0] data, logic [4:0] idx);
      int gap;
      req_tuser <= kind;
      req_tdata <= {3'b000, idx, data};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (req_tready !== 1'b1);
      console_out_q.push_back(console_event(kind, data, idx));
      sent_total++;
      gap = sender_idle_en ? gap_len() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_rx(logic [7:0] data);
      send_request(KIND_RX, data, 5'($urandom_range(0, 31)));
   endtask

   task automatic send_tx_ready();
      send_request(KIND_TX_READY, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
   endtask

   task automatic send_read();
      int idx;
      idx = pick_stored_index();
      if (idx < 0) send_tx_ready();
      else send_request(KIND_READ, 8'($urandom_range(0, 255)), 5'(idx));
   endtask

   task automatic send_random_item();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40)
         send_rx(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : typed_char());
      else if (pick < 70)
         send_tx_ready();
      else if (pick < 85)
         send_request(KIND_HOST, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
      else
         send_read();
   endtask

   task automatic wait_responses_done();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (console_out_q.size() != 0);
   endtask

   task automatic test_corner_events();
      sender_idle_en = 1'b1;
      sink_idle_en = 1'b1;
      send_tx_ready();                  // ready with nothing queued
      send_rx(CH_CR);                   // empty line
      send_rx(CH_BS | BIT7);            // erase on empty line
      send_rx(8'h01);
      send_rx(8'h1F);
      send_rx(8'h00);
      send_rx(8'h41);
      send_rx(8'hDA);
      send_rx(8'h7F);
      send_rx(8'h20);
      send_rx(8'hFF);
      send_rx(CH_BS);
      send_request(KIND_READ, 8'hFF, 5'd1);
      send_request(KIND_READ, 8'h00, 5'd0);
      send_request(KIND_HOST, 8'h00, 5'd31);
      send_request(KIND_HOST, 8'hFF, 5'd0);
      send_rx(CH_CR | BIT7);
      repeat (3) send_tx_ready();
      wait_responses_done();
   endtask

   task automatic test_typed_lines(int quota);
      int stop_at;
      int len;
      stop_at = sent_total + quota;
      while (sent_total < stop_at) begin
         sender_idle_en = ($urandom_range(0, 3) != 0);
         sink_idle_en = ($urandom_range(0, 3) != 0);
         len = ($urandom_range(0, 4) == 0) ? $urandom_range(31, 45) : $urandom_range(0, 12);
         repeat (len) begin
            send_rx(typed_char());
            if ($urandom_range(0, 99) < 55) send_tx_ready();
         end
         send_rx(CH_CR | ($urandom_range(0, 1) ? BIT7 : 8'h00));
         repeat ($urandom_range(0, 3)) send_read();
         repeat ($urandom_range(0, 4)) send_tx_ready();
      end
   endtask

   task automatic test_queue_overflow(int rounds);
      sender_idle_en = 1'b1;
      sink_idle_en = 1'b1;
      repeat (rounds) begin
         repeat ($urandom_range(50, 90)) begin
            if ($urandom_range(0, 9) == 0) send_tx_ready();
            else if ($urandom_range(0, 4) == 0) send_rx(typed_char());
            else send_request(KIND_HOST, 8'($urandom_range(0, 255)),
                              5'($urandom_range(0, 31)));
         end
         while (tx_busy) send_tx_ready();
         repeat ($urandom_range(1, 3)) send_tx_ready();
      end
   endtask

   task automatic test_rsp_backpressure(int count);
      sender_idle_en = 1'b0;
      sink_idle_en = 1'b1;
      hold_off_req = 1'b1;
      repeat (count) send_random_item();
      wait_responses_done();
      sender_idle_en = 1'b1;
      repeat (count) send_random_item();
   endtask

   task automatic test_random_mix(int quota);
      int stop_at;
      stop_at = sent_total + quota;
      while (sent_total < stop_at) begin
         sender_idle_en = ($urandom_range(0, 2) != 0);
         sink_idle_en = ($urandom_range(0, 2) != 0);
         repeat (50) send_random_item();
      end
   endtask

   task automatic finish_run();
      wait_responses_done();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && console_out_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_corner_events();
      test_typed_lines(700);
      test_queue_overflow(3);
      test_rsp_backpressure(65);
      test_random_mix(350);
      finish_run();
   end

   initial begin : rsp_sink
      int stall;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end else begin
            stall = sink_idle_en ? gap_len() : 0;
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end else begin
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      console_out_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (console_out_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("response with no request pending: tdata %h tuser %h",
                        rsp_tdata, rsp_tuser);
         end else begin
            want = console_out_q.pop_front();
            flag_field("send_valid", 8'(want.send_valid), 8'(rsp_tuser[0]));
            flag_field("send_byte", want.send_byte, rsp_tdata[7:0]);
            flag_field("line_done", 8'(want.line_done), 8'(rsp_tuser[1]));
            flag_field("line_length", 8'(want.line_length), 8'(rsp_tdata[12:8]));
            flag_field("read_char", want.read_char, rsp_tdata[20:13]);
            flag_field("queue_full", 8'(want.queue_full), 8'(rsp_tdata[21]));
            flag_field("sender_busy", 8'(want.sender_busy), 8'(rsp_tdata[22]));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready === 1'b1) || (rsp_tvalid === 1'b1 && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

endmodule
